@@ hw/rtl/lcrs_pkg.sv @@
// Package for the line counter with return stack.
// Holds command and status codes, field widths and parameter defaults.
// No dependencies.
package lcrs_pkg;

   localparam int TARGET_BITS       = 16;
   localparam int CFG_BITS          = 16;
   localparam int OUT_LINE_BITS     = 16;
   localparam int CMD_BITS          = 3;
   localparam int STATUS_BITS       = 3;

   localparam int STACK_DEPTH_DEF   = 16;
   localparam int LINE_BITS_DEF     = 16;

   localparam logic [CFG_BITS-1:0] LAST_LINE_RESET = 16'hFFFF;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_STEP   = 3'd0,
      CMD_JUMP   = 3'd1,
      CMD_CALL   = 3'd2,
      CMD_RETURN = 3'd3,
      CMD_LAST   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_ILLEGAL = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_HALTED  = 3'd4;

   // shift control for the row of stack cells
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

@@ hw/rtl/lcrs_cell.sv @@
// One entry of the return stack, a link in the chain of stack cells.
// Takes its neighbor's value on push or pop. Depends on lcrs_pkg.
module lcrs_cell import lcrs_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic                 clock,
   input  stack_ctl_type        ctl,
   input  logic [LINE_BITS-1:0] prev_value,
   input  logic [LINE_BITS-1:0] next_value,
   output logic [LINE_BITS-1:0] value
);

   logic [LINE_BITS-1:0] value_ff;
   logic [LINE_BITS-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = prev_value;
      end else if (ctl.pop) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ hw/rtl/line_counter_with_return_stack.sv @@
// Line counter with return stack: keeps the current line of a small interpreter
// (reset 1) and a return stack of STACK_DEPTH lines built as a row of shift
// cells whose first cell is the top. One request is accepted every cycle while
// not stalled; its response is registered in the next cycle. A new request is
// taken whenever the output register is empty or is drained in the same cycle.
// Jump or call past csr last_line, or return on an empty stack, halts the block;
// afterwards every request returns the held line with status "already halted".
// A call on a full stack is refused with status "stack full". The user must write
// last_line through the csr channel, which is always ready, only while idle; the
// block itself does not enforce it. Depends on lcrs_pkg and lcrs_cell.
module line_counter_with_return_stack import lcrs_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int LINE_BITS   = LINE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_BITS-1:0]      req_command,
   input  logic [TARGET_BITS-1:0]   req_target_line,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_LINE_BITS-1:0] rsp_current_line,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic                     rsp_halted,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CFG_BITS-1:0]      csr_last_line
);

   localparam int FILL_BITS = $clog2(STACK_DEPTH + 1);
   localparam int CMP_BITS  = (LINE_BITS > CFG_BITS) ? LINE_BITS : CFG_BITS;
   localparam logic [CMP_BITS-1:0]  LINE_MASK = CMP_BITS'({LINE_BITS{1'b1}});
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(STACK_DEPTH);

   logic [CFG_BITS-1:0]      last_line_ff;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic                     stopped_ff, stopped_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_LINE_BITS-1:0] rsp_line_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff, status_in;
   logic                     rsp_halted_ff;

   logic                     req_accept;
   logic [CMP_BITS-1:0]      last_cmp;
   logic                     illegal;
   logic                     stack_full;
   logic                     stack_empty;
   stack_ctl_type            stack_ctl;
   logic [LINE_BITS-1:0]     cell_value [STACK_DEPTH];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign last_cmp    = CMP_BITS'(last_line_ff) & LINE_MASK;
   assign illegal     = CMP_BITS'(req_target_line) > last_cmp;
   assign stack_full  = fill_ff == FILL_FULL;
   assign stack_empty = fill_ff == '0;

   always_comb begin
      line_in        = line_ff;
      fill_in        = fill_ff;
      stopped_in     = stopped_ff;
      status_in      = ST_OK;
      stack_ctl.push = 1'b0;
      stack_ctl.pop  = 1'b0;
      if (stopped_ff) begin
         status_in = ST_HALTED;
      end else begin
         case (cmd_type'(req_command))
            CMD_STEP: begin
               if (line_ff != '1) begin
                  line_in = line_ff + 1'b1;
               end
            end
            CMD_JUMP: begin
               if (illegal) begin
                  status_in  = ST_ILLEGAL;
                  stopped_in = 1'b1;
               end else begin
                  line_in = LINE_BITS'(req_target_line);
               end
            end
            CMD_CALL: begin
               // bounds check wins over the full check
               if (illegal) begin
                  status_in  = ST_ILLEGAL;
                  stopped_in = 1'b1;
               end else if (stack_full) begin
                  status_in = ST_FULL;
               end else begin
                  stack_ctl.push = 1'b1;
                  fill_in        = fill_ff + 1'b1;
                  line_in        = LINE_BITS'(req_target_line);
               end
            end
            CMD_RETURN: begin
               if (stack_empty) begin
                  status_in  = ST_EMPTY;
                  stopped_in = 1'b1;
               end else begin
                  stack_ctl.pop = 1'b1;
                  fill_in       = fill_ff - 1'b1;
                  line_in       = cell_value[0];
               end
            end
            CMD_LAST: begin
               line_in = LINE_BITS'(last_cmp);
            end
            default: begin
               // read and unused codes leave state alone
            end
         endcase
      end
      // drop all updates unless a request is taken
      if (!req_accept) begin
         stack_ctl.push = 1'b0;
         stack_ctl.pop  = 1'b0;
      end
   end

   generate
      for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic [LINE_BITS-1:0] prev_value;
         logic [LINE_BITS-1:0] next_value;
         if (i == 0) begin : g_first
            assign prev_value = line_ff;
         end else begin : g_mid
            assign prev_value = cell_value[i-1];
         end
         if (i == STACK_DEPTH - 1) begin : g_last
            assign next_value = cell_value[i];
         end else begin : g_inner
            assign next_value = cell_value[i+1];
         end
         lcrs_cell #(
            .LINE_BITS (LINE_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (stack_ctl),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[i])
         );
      end
   endgenerate

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_line_ff <= LAST_LINE_RESET;
         line_ff      <= LINE_BITS'(1);
         fill_ff      <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            last_line_ff <= csr_last_line;
         end
         if (req_accept) begin
            line_ff    <= line_in;
            fill_ff    <= fill_in;
            stopped_ff <= stopped_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_line_ff   <= OUT_LINE_BITS'(line_in);
         rsp_status_ff <= status_in;
         rsp_halted_ff <= stopped_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_line = rsp_line_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_halted       = rsp_halted_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("stack fill beyond depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt cleared without reset");

   a_halt_holds_line: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> ($stable(line_ff) && $stable(fill_ff)))
      else $error("state changed while halted");

   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && stack_ctl.push) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("push did not advance fill");

   a_rsp_halt_status: assert property (@(posedge clock) disable iff (reset)
      (req_accept && stopped_ff) |=> (rsp_halted && rsp_status == ST_HALTED))
      else $error("halted request without halted status");

endmodule

@@ tb/lcrs_line_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the line counter with return stack: watches the request,
// response and csr channels, predicts each response and compares it field by field.
// Depends on lcrs_pkg.
module lcrs_line_checker import lcrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [CMD_BITS-1:0]      req_command,
   input  logic [TARGET_BITS-1:0]   req_target_line,

   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [OUT_LINE_BITS-1:0] rsp_current_line,
   input  logic [STATUS_BITS-1:0]   rsp_status,
   input  logic                     rsp_halted,

   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CFG_BITS-1:0]      csr_last_line,

   output int                       fail_count,
   output int                       pending,
   output int                       checked_count
);

   typedef struct packed {
      logic [OUT_LINE_BITS-1:0] line;
      logic [STATUS_BITS-1:0]   status;
      logic                     halted;
   } line_result_type;

   line_result_type       awaited_q[$];

   logic [LINE_BITS_DEF-1:0] cur_line;
   logic [LINE_BITS_DEF-1:0] ret_stack [STACK_DEPTH_DEF];
   int unsigned              depth_used;
   logic                     is_stopped;
   logic [CFG_BITS-1:0]      last_line_cfg;

   // apply one command to the shadow line counter and return its response
   function automatic line_result_type next_line_result(input logic [CMD_BITS-1:0] cmd,
                                                        input logic [TARGET_BITS-1:0] tgt);
      line_result_type res;
      logic [STATUS_BITS-1:0] st;
      st = ST_OK;
      if (is_stopped) begin
         st = ST_HALTED;
      end else begin
         case (cmd)
            CMD_STEP: begin
               if (cur_line != '1) cur_line = cur_line + 1'b1;
            end
            CMD_JUMP: begin
               if (tgt > last_line_cfg) begin
                  st = ST_ILLEGAL;
                  is_stopped = 1'b1;
               end else begin
                  cur_line = tgt;
               end
            end
            CMD_CALL: begin
               // bounds check wins over the full-stack refusal
               if (tgt > last_line_cfg) begin
                  st = ST_ILLEGAL;
                  is_stopped = 1'b1;
               end else if (depth_used >= STACK_DEPTH_DEF) begin
                  st = ST_FULL;
               end else begin
                  ret_stack[depth_used] = cur_line;
                  depth_used++;
                  cur_line = tgt;
               end
            end
            CMD_RETURN: begin
               if (depth_used == 0) begin
                  st = ST_EMPTY;
                  is_stopped = 1'b1;
               end else begin
                  depth_used--;
                  cur_line = ret_stack[depth_used];
               end
            end
            CMD_LAST: begin
               cur_line = last_line_cfg;
            end
            default: begin
            end
         endcase
      end
      res.line   = cur_line;
      res.status = st;
      res.halted = is_stopped;
      return res;
   endfunction

   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         cur_line      = 16'd1;
         depth_used    = 0;
         is_stopped    = 1'b0;
         last_line_cfg = LAST_LINE_RESET;
         awaited_q.delete();
      end else begin
         // check the response first: it can never belong to this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               $display("%0t: response with no request waiting: line %h status %0d halted %0b",
                        $time, rsp_current_line, rsp_status, rsp_halted);
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               checked_count++;
               if (rsp_current_line !== want.line) begin
                  $display("%0t: current_line mismatch: expected %h actual %h",
                           $time, want.line, rsp_current_line);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_halted !== want.halted) begin
                  $display("%0t: halted mismatch: expected %0b actual %0b",
                           $time, want.halted, rsp_halted);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) last_line_cfg = csr_last_line;
         if (req_valid && !req_stall)
            awaited_q.push_back(next_line_result(req_command, req_target_line));
      end
      pending = awaited_q.size();
   end

endmodule

@@ tb/tb_line_counter_with_return_stack.sv @@
`timescale 1ns / 1ps
// Testbench top for the line counter with return stack: drives requests, csr writes
// and response stalls, and reports the verdict. Depends on lcrs_pkg, the block and
// lcrs_line_checker.
module tb_line_counter_with_return_stack;
   import lcrs_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;
   localparam int IDLE_LIMIT  = 1000;
   localparam int HOLD_CYCLES = 80;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_BITS-1:0]      req_command;
   logic [TARGET_BITS-1:0]   req_target_line;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [OUT_LINE_BITS-1:0] rsp_current_line;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic                     rsp_halted;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CFG_BITS-1:0]      csr_last_line;

   int          fail_count;
   int          pending;
   int          checked_count;
   int          sent_count;
   int          setting_count;
   int          idle_cycles;
   bit          quiet;
   bit          long_hold;
   int unsigned shadow_fill;
   logic [CFG_BITS-1:0] shadow_last;
   string       halt_kind;

   line_counter_with_return_stack #(
      .STACK_DEPTH (STACK_DEPTH_DEF),
      .LINE_BITS   (LINE_BITS_DEF)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_target_line  (req_target_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_current_line (rsp_current_line),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_last_line    (csr_last_line)
   );

   lcrs_line_checker i_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_target_line  (req_target_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_current_line (rsp_current_line),
      .rsp_status       (rsp_status),
      .rsp_halted       (rsp_halted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_last_line    (csr_last_line),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked_count    (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time, pending);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request and hold it until accepted
   task automatic send_req(input logic [CMD_BITS-1:0] cmd, input logic [TARGET_BITS-1:0] tgt);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_target_line <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      // track stack depth so that returns never hit an empty stack by accident
      if (cmd == CMD_CALL && tgt <= shadow_last && shadow_fill < STACK_DEPTH_DEF)
         shadow_fill++;
      else if (cmd == CMD_RETURN && shadow_fill > 0)
         shadow_fill--;
   endtask

   // drop valid and wait for every outstanding response
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_last_line(input logic [CFG_BITS-1:0] value);
      drain();
      csr_valid     <= 1'b1;
      csr_last_line <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      shadow_last = value;
      setting_count++;
   endtask

   function automatic logic [TARGET_BITS-1:0] legal_target();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return shadow_last;
         default: return TARGET_BITS'($urandom_range(shadow_last, 0));
      endcase
   endfunction

   // filler between a call and its return
   task automatic body_cmds();
      int n;
      n = $urandom_range(0, 3);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: send_req(CMD_STEP, TARGET_BITS'($urandom));
            1: send_req(CMD_READ, TARGET_BITS'($urandom));
            2: send_req(CMD_SPARE6, TARGET_BITS'($urandom));
            default: send_req(CMD_SPARE7, TARGET_BITS'($urandom));
         endcase
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int depth;
      int r;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // nested subroutine calls with matching returns
            depth = $urandom_range(1, 4);
            repeat (depth) begin
               send_req(CMD_CALL, legal_target());
               body_cmds();
            end
            repeat (depth) begin
               if (shadow_fill > 0) begin
                  send_req(CMD_RETURN, TARGET_BITS'($urandom));
                  body_cmds();
               end
            end
         end else if (r < 45) begin
            // fill the stack, get refused, unwind some or all of it
            while (shadow_fill < STACK_DEPTH_DEF) send_req(CMD_CALL, legal_target());
            repeat ($urandom_range(1, 2)) send_req(CMD_CALL, legal_target());
            repeat ($urandom_range(1, STACK_DEPTH_DEF))
               send_req(CMD_RETURN, TARGET_BITS'($urandom));
         end else if (r < 60) begin
            send_req(CMD_JUMP, legal_target());
         end else if (r < 68) begin
            send_req(CMD_LAST, TARGET_BITS'($urandom));
            repeat ($urandom_range(0, 2)) send_req(CMD_STEP, TARGET_BITS'($urandom));
         end else if (r < 82) begin
            repeat ($urandom_range(1, 5)) send_req(CMD_STEP, TARGET_BITS'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: send_req(CMD_READ, TARGET_BITS'($urandom));
               1: send_req(CMD_SPARE6, TARGET_BITS'($urandom));
               2: send_req(CMD_SPARE7, TARGET_BITS'($urandom));
               default: begin
                  if (shadow_fill > 0) send_req(CMD_RETURN, TARGET_BITS'($urandom));
                  else send_req(CMD_READ, TARGET_BITS'($urandom));
               end
            endcase
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_READ;
      req_target_line = '0;
      csr_valid       = 1'b0;
      csr_last_line   = '0;
      shadow_fill     = 0;
      shadow_last     = LAST_LINE_RESET;
      halt_kind       = "none";
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, saturation, zero target, full stack
      write_last_line(16'hFFFF);
      send_req(CMD_READ, 16'h0000);
      send_req(CMD_SPARE7, 16'hFFFF);
      send_req(CMD_JUMP, 16'hFFFF);
      send_req(CMD_STEP, 16'h0000);
      send_req(CMD_JUMP, 16'h0000);
      send_req(CMD_LAST, 16'h0000);
      send_req(CMD_CALL, 16'h5555);
      send_req(CMD_RETURN, 16'hAAAA);
      for (int i = 0; i < STACK_DEPTH_DEF; i++)
         send_req(CMD_CALL, (i % 2 == 0) ? 16'hAAAA : 16'h5555);
      send_req(CMD_CALL, 16'h0F0F);

      // random phases over several last_line settings
      write_last_line(16'd1);
      run_random(270);
      write_last_line(16'd0);
      run_random(270);
      write_last_line(CFG_BITS'($urandom_range(2, 65534)));
      run_random(270);

      write_last_line(16'hFFFF);
      run_random(90);
      long_hold = 1'b1;
      run_random(90);
      drain();
      run_random(90);

      write_last_line(CFG_BITS'($urandom_range(2, 40)));
      run_random(270);

      quiet = 1'b1;
      write_last_line(CFG_BITS'($urandom_range(1, 65534)));
      run_random(270);

      // end with one halting case, then show every command is ignored
      case ($urandom_range(0, 2))
         0: begin
            halt_kind = "jump past the last line";
            send_req(CMD_JUMP, TARGET_BITS'($urandom_range(65535, int'(shadow_last) + 1)));
         end
         1: begin
            halt_kind = "call past the last line";
            send_req(CMD_CALL, TARGET_BITS'($urandom_range(65535, int'(shadow_last) + 1)));
         end
         default: begin
            halt_kind = "return on an empty stack";
            while (shadow_fill > 0) send_req(CMD_RETURN, TARGET_BITS'($urandom));
            send_req(CMD_RETURN, TARGET_BITS'($urandom));
         end
      endcase
      for (int c = 0; c < 8; c++) send_req(CMD_BITS'(c), TARGET_BITS'($urandom));

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (10) @(posedge clock);

      $display("Summary: %0d requests under %0d last_line settings, %0d responses checked",
               sent_count, setting_count, checked_count);
      $display("Summary: nested calls, full-stack refusals, saturating steps, halt by %s",
               halt_kind);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
